// ===== hw/rtl/ssps_pkg.sv =====
// Shared types and constants for the servo slew pulse scheduler.
package ssps_pkg;

   // Field widths
   localparam int AngleWidth     = 8;
   localparam int PulseWidth     = 12;
   localparam int ElapsedWidth   = 16;
   localparam int ReqAngleWidth  = 16;

   // Serial mapper sizing: the magnitude product needs 20 bits
   localparam int ProdWidth      = 20;
   localparam int MulSteps       = AngleWidth;
   localparam int DivSteps       = ProdWidth;
   localparam int StepCountWidth = $clog2(DivSteps);
   localparam int SumWidth       = ProdWidth + 2;

   // Configuration port
   localparam int CsrAddrWidth   = 5;
   localparam int CsrDataWidth   = 32;
   localparam int RegIndexWidth  = 3;

   // Reset values
   localparam logic [AngleWidth-1:0]   ResetAngleLow   = 8'd0;
   localparam logic [AngleWidth-1:0]   ResetAngleHigh  = 8'd180;
   localparam logic [AngleWidth-1:0]   ResetCentre     = 8'd90;
   localparam logic [PulseWidth-1:0]   ResetPulseLow   = 12'd500;
   localparam logic [PulseWidth-1:0]   ResetPulseHigh  = 12'd2500;
   localparam logic [AngleWidth-1:0]   ResetStep       = 8'd10;
   localparam logic [ElapsedWidth-1:0] ResetHold       = 16'd500;
   localparam logic [AngleWidth-1:0]   ResetRefresh    = 8'd20;

   localparam logic [PulseWidth-1:0]   PulseMax        = '1;

   // Operation codes on the request tuser
   localparam logic OpTick = 1'b0;
   localparam logic OpSet  = 1'b1;

   // Register map indexes
   typedef enum logic [RegIndexWidth-1:0] {
      REG_ANGLE_LOW  = 3'd0,
      REG_ANGLE_HIGH = 3'd1,
      REG_CENTRE     = 3'd2,
      REG_PULSE_LOW  = 3'd3,
      REG_PULSE_HIGH = 3'd4,
      REG_STEP       = 3'd5,
      REG_HOLD       = 3'd6,
      REG_REFRESH    = 3'd7
   } csr_reg_type;

   // Mapper sequencer states
   typedef enum logic [1:0] {
      MAP_IDLE,
      MAP_MUL,
      MAP_DIV,
      MAP_DONE
   } map_state_type;

   // Mapping limits handed to the mapper
   typedef struct packed {
      logic [AngleWidth-1:0] angle_low;
      logic [AngleWidth-1:0] angle_high;
      logic [PulseWidth-1:0] pulse_low;
      logic [PulseWidth-1:0] pulse_high;
   } map_cfg_type;

   // Control from the scheduler to the mapper
   typedef struct packed {
      logic                  start;
      logic                  ack;
      logic [AngleWidth-1:0] angle;
   } map_ctrl_type;

   // Status from the mapper back to the scheduler
   typedef struct packed {
      logic                  idle;
      logic                  done;
      logic [PulseWidth-1:0] width;
   } map_status_type;

endpackage

// ===== hw/rtl/ssps_map.sv =====
// Bit-serial angle to pulse width mapper: shift-add multiply, then restoring divide.
module ssps_map
   import ssps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  map_cfg_type    cfg,
   input  map_ctrl_type   ctrl,
   output map_status_type sts
);

   map_state_type state_ff, state_in;

   logic [StepCountWidth-1:0] cnt_ff, cnt_in;
   logic [ProdWidth-1:0]      work_ff, work_in;
   logic [AngleWidth-1:0]     mplier_ff, mplier_in;
   logic [PulseWidth-1:0]     mcand_ff, mcand_in;
   logic [AngleWidth-1:0]     dvsr_ff, dvsr_in;
   logic [AngleWidth-1:0]     rem_ff, rem_in;
   logic                      neg_ff, neg_in;

   logic [AngleWidth:0]   diff_a, diff_d, neg_a, neg_d;
   logic [PulseWidth:0]   diff_b, neg_b;
   logic [AngleWidth:0]   rem_shift;
   logic                  q_bit;
   logic [SumWidth-1:0]   q_signed, w_sum;
   logic                  cnt_zero;

   // Operand differences and their magnitudes at start
   always_comb begin
      diff_a = {1'b0, ctrl.angle} - {1'b0, cfg.angle_low};
      diff_d = {1'b0, cfg.angle_high} - {1'b0, cfg.angle_low};
      diff_b = {1'b0, cfg.pulse_high} - {1'b0, cfg.pulse_low};
      neg_a  = -diff_a;
      neg_d  = -diff_d;
      neg_b  = -diff_b;
   end

   // One restoring division step
   always_comb begin
      rem_shift = {rem_ff, work_ff[ProdWidth-1]};
      q_bit     = (rem_shift >= {1'b0, dvsr_ff});
   end

   assign cnt_zero = (cnt_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MAP_IDLE: begin
            if (ctrl.start) state_in = MAP_MUL;
         end
         MAP_MUL: begin
            if (cnt_zero) state_in = MAP_DIV;
         end
         MAP_DIV: begin
            if (cnt_zero) state_in = MAP_DONE;
         end
         MAP_DONE: begin
            if (ctrl.ack) state_in = MAP_IDLE;
         end
         default: state_in = MAP_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      cnt_in    = cnt_ff;
      work_in   = work_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      dvsr_in   = dvsr_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      case (state_ff)
         MAP_IDLE: begin
            cnt_in    = StepCountWidth'(MulSteps - 1);
            work_in   = '0;
            rem_in    = '0;
            mplier_in = diff_a[AngleWidth] ? neg_a[AngleWidth-1:0] : diff_a[AngleWidth-1:0];
            mcand_in  = diff_b[PulseWidth] ? neg_b[PulseWidth-1:0] : diff_b[PulseWidth-1:0];
            dvsr_in   = diff_d[AngleWidth] ? neg_d[AngleWidth-1:0] : diff_d[AngleWidth-1:0];
            neg_in    = diff_a[AngleWidth] ^ diff_b[PulseWidth] ^ diff_d[AngleWidth];
         end
         MAP_MUL: begin
            // Most significant multiplier bit first
            work_in   = {work_ff[ProdWidth-2:0], 1'b0}
                      + (mplier_ff[AngleWidth-1] ? ProdWidth'(mcand_ff) : '0);
            mplier_in = {mplier_ff[AngleWidth-2:0], 1'b0};
            cnt_in    = cnt_zero ? StepCountWidth'(DivSteps - 1) : cnt_ff - 1'b1;
         end
         MAP_DIV: begin
            rem_in  = q_bit ? AngleWidth'(rem_shift - {1'b0, dvsr_ff})
                            : rem_shift[AngleWidth-1:0];
            work_in = {work_ff[ProdWidth-2:0], q_bit};
            cnt_in  = cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      work_ff   <= work_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      dvsr_ff   <= dvsr_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
   end

   // Apply the sign to the quotient, add the low pulse width and saturate
   always_comb begin
      q_signed = neg_ff ? -SumWidth'(work_ff) : SumWidth'(work_ff);
      w_sum    = q_signed + SumWidth'(cfg.pulse_low);
   end

   // Status outputs
   always_comb begin
      sts.idle = (state_ff == MAP_IDLE);
      sts.done = (state_ff == MAP_DONE);
      if (cfg.angle_high == cfg.angle_low) begin
         sts.width = cfg.pulse_low;
      end else if (w_sum[SumWidth-1]) begin
         sts.width = '0;
      end else if (w_sum > SumWidth'(PulseMax)) begin
         sts.width = PulseMax;
      end else begin
         sts.width = w_sum[PulseWidth-1:0];
      end
   end

endmodule

// ===== hw/rtl/servo_slew_pulse_scheduler_unit.sv =====
// Top level of the servo slew pulse scheduler: registers, tick logic and item handshakes.
// A set item updates the target angle and gives no result item.
// A tick item raises its result item after a serial multiply and a restoring divide in
// the width mapper and the load of the output register, which waits for a free result slot.
// The mapper takes no new request item until its result has been handed to the output register.
// Reset (synchronous, active high) loads register defaults, centers the angles, clears counters.
module servo_slew_pulse_scheduler_unit
   import ssps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqAngleWidth-1:0] req_tdata,   // [15:0] requested_angle
   input  logic                     req_tuser,   // [0] op
   // Result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // [0] pulse_fire, [12:1] pulse_width_us,
                                                 // [20:13] present_angle, [21] moving,
                                                 // [22] train_stopped, [23] zero
   // Configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CsrAddrWidth-1:0]  csr_paddr,
   input  logic [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);

   // Configuration registers
   logic [AngleWidth-1:0]   angle_low_ff, angle_high_ff, centre_ff;
   logic [PulseWidth-1:0]   pulse_low_ff, pulse_high_ff;
   logic [AngleWidth-1:0]   step_ff, refresh_ff;
   logic [ElapsedWidth-1:0] hold_ff;

   // Scheduler state
   logic [AngleWidth-1:0]   cur_ff, cur_in;
   logic [AngleWidth-1:0]   tgt_ff, tgt_in;
   logic                    reached_ff, reached_in;
   logic [ElapsedWidth-1:0] since_step_ff, since_step_in;
   logic [ElapsedWidth-1:0] since_refresh_ff, since_refresh_in;
   logic [ElapsedWidth-1:0] since_arrival_ff, since_arrival_in;
   logic                    fire_ff, fire_in;
   logic                    stopped_ff, stopped_in;

   // Output register
   logic                    rsp_valid_ff;
   logic [23:0]             rsp_data_ff;

   logic                    req_accept, tick_accept, set_accept, csr_write;
   logic signed [ReqAngleWidth:0] req_angle_ext;
   logic [RegIndexWidth-1:0]      csr_index;

   map_cfg_type    map_cfg;
   map_ctrl_type   map_ctrl;
   map_status_type map_sts;

   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index   = csr_paddr[CsrAddrWidth-1:2];

   assign req_tready  = map_sts.idle;
   assign req_accept  = req_tvalid & req_tready;
   assign tick_accept = req_accept & (req_tuser == OpTick);
   assign set_accept  = req_accept & (req_tuser == OpSet);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_low_ff  <= ResetAngleLow;
         angle_high_ff <= ResetAngleHigh;
         centre_ff     <= ResetCentre;
         pulse_low_ff  <= ResetPulseLow;
         pulse_high_ff <= ResetPulseHigh;
         step_ff       <= ResetStep;
         hold_ff       <= ResetHold;
         refresh_ff    <= ResetRefresh;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_ANGLE_LOW:  angle_low_ff  <= csr_pwdata[AngleWidth-1:0];
            REG_ANGLE_HIGH: angle_high_ff <= csr_pwdata[AngleWidth-1:0];
            REG_CENTRE:     centre_ff     <= csr_pwdata[AngleWidth-1:0];
            REG_PULSE_LOW:  pulse_low_ff  <= csr_pwdata[PulseWidth-1:0];
            REG_PULSE_HIGH: pulse_high_ff <= csr_pwdata[PulseWidth-1:0];
            REG_STEP:       step_ff       <= csr_pwdata[AngleWidth-1:0];
            REG_HOLD:       hold_ff       <= csr_pwdata[ElapsedWidth-1:0];
            REG_REFRESH:    refresh_ff    <= csr_pwdata[AngleWidth-1:0];
            default: ;
         endcase
      end
   end

   // Configuration reads
   always_comb begin
      case (csr_reg_type'(csr_index))
         REG_ANGLE_LOW:  csr_prdata = CsrDataWidth'(angle_low_ff);
         REG_ANGLE_HIGH: csr_prdata = CsrDataWidth'(angle_high_ff);
         REG_CENTRE:     csr_prdata = CsrDataWidth'(centre_ff);
         REG_PULSE_LOW:  csr_prdata = CsrDataWidth'(pulse_low_ff);
         REG_PULSE_HIGH: csr_prdata = CsrDataWidth'(pulse_high_ff);
         REG_STEP:       csr_prdata = CsrDataWidth'(step_ff);
         REG_HOLD:       csr_prdata = CsrDataWidth'(hold_ff);
         REG_REFRESH:    csr_prdata = CsrDataWidth'(refresh_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req_angle_ext = {req_tdata[ReqAngleWidth-1], req_tdata};

   // Set and tick updates of the scheduler state
   always_comb begin
      cur_in           = cur_ff;
      tgt_in           = tgt_ff;
      reached_in       = reached_ff;
      since_step_in    = since_step_ff;
      since_refresh_in = since_refresh_ff;
      since_arrival_in = since_arrival_ff;
      fire_in          = fire_ff;
      stopped_in       = stopped_ff;
      if (set_accept) begin
         // Clamp the signed request into the limits, low limit checked first
         if (req_angle_ext < $signed({{(ReqAngleWidth-AngleWidth+1){1'b0}}, angle_low_ff})) begin
            tgt_in = angle_low_ff;
         end else if (req_angle_ext >
                      $signed({{(ReqAngleWidth-AngleWidth+1){1'b0}}, angle_high_ff})) begin
            tgt_in = angle_high_ff;
         end else begin
            tgt_in = req_tdata[AngleWidth-1:0];
         end
      end else if (tick_accept) begin
         // Saturating elapsed counters
         since_step_in    = (since_step_ff == '1) ? since_step_ff : since_step_ff + 1'b1;
         since_refresh_in = (since_refresh_ff == '1) ? since_refresh_ff
                                                     : since_refresh_ff + 1'b1;
         since_arrival_in = (since_arrival_ff == '1) ? since_arrival_ff
                                                     : since_arrival_ff + 1'b1;
         // Slew one degree per step interval, or mark the arrival
         if (cur_ff != tgt_ff) begin
            if (since_step_in >= ElapsedWidth'(step_ff)) begin
               since_step_in = '0;
               cur_in = (tgt_ff > cur_ff) ? cur_ff + 1'b1 : cur_ff - 1'b1;
            end
            reached_in = 1'b0;
         end else if (!reached_ff) begin
            reached_in       = 1'b1;
            since_arrival_in = '0;
         end
         // Hold window and refresh pulse
         stopped_in = reached_in & (since_arrival_in >= hold_ff);
         fire_in    = !stopped_in && (since_refresh_in >= ElapsedWidth'(refresh_ff));
         if (fire_in) since_refresh_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff           <= ResetCentre;
         tgt_ff           <= ResetCentre;
         reached_ff       <= 1'b0;
         since_step_ff    <= '0;
         since_refresh_ff <= '0;
         since_arrival_ff <= '0;
      end else begin
         cur_ff           <= cur_in;
         tgt_ff           <= tgt_in;
         reached_ff       <= reached_in;
         since_step_ff    <= since_step_in;
         since_refresh_ff <= since_refresh_in;
         since_arrival_ff <= since_arrival_in;
      end
   end

   always_ff @(posedge clock) begin
      fire_ff    <= fire_in;
      stopped_ff <= stopped_in;
   end

   // Width mapper
   assign map_cfg.angle_low  = angle_low_ff;
   assign map_cfg.angle_high = angle_high_ff;
   assign map_cfg.pulse_low  = pulse_low_ff;
   assign map_cfg.pulse_high = pulse_high_ff;

   assign map_ctrl.start = tick_accept;
   assign map_ctrl.angle = cur_in;
   assign map_ctrl.ack   = map_sts.done & (!rsp_valid_ff | rsp_tready);

   ssps_map u_map (
      .clock (clock),
      .reset (reset),
      .cfg   (map_cfg),
      .ctrl  (map_ctrl),
      .sts   (map_sts)
   );

   // Output register: loads when the mapper finishes and the slot is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (map_ctrl.ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (map_ctrl.ack) begin
         rsp_data_ff <= {1'b0, stopped_ff, (cur_ff != tgt_ff), cur_ff, map_sts.width, fire_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A tick item occupies the mapper, so no item is taken in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> !req_tready)
      else $error("request taken while the mapper works on a tick");

   // A result item only appears after the mapper has finished
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(map_sts.done))
      else $error("result item raised without a finished mapping");

   // The current angle moves by at most one degree per cycle outside reset
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cur_ff == $past(cur_ff)) ||
                        (cur_ff == $past(cur_ff) + 8'd1) ||
                        (cur_ff == $past(cur_ff) - 8'd1))
      else $error("current angle jumped by more than one degree");

endmodule
